// ----- hw/rtl/largest_bin_spill_policy_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the largest-bin spill policy block
// Concurrent checks on clk with synchronous reset rst, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LARGEST_BIN_SPILL_POLICY_TOP_DEFINES_SVH
`define LARGEST_BIN_SPILL_POLICY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LBSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LBSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LBSP_ASSERT_NOW(lbl, ante, cons, msg)
`define LBSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/lbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lbsp_pkg
// Widths, register indexes, codes and shared helpers of the spill policy.
// ----------------------------------------------------------------------------
package lbsp_pkg;

  localparam int CNT_W        = 48;
  localparam int ADD_W        = 32;
  localparam int BIN_PORT_W   = 6;
  localparam int NUM_BINS_DEF = 64;
  localparam int CFG_IDX_W    = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKAGE_LIMIT = 1'b1;

  localparam logic [CNT_W-1:0] TOTAL_LIMIT_RST   = 48'd1073741824;
  localparam logic [CNT_W-1:0] PACKAGE_LIMIT_RST = 48'd16777216;

  // command and cause codes
  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_FINISH  = 1'b1;
  localparam logic CAUSE_LIMIT = 1'b0;
  localparam logic CAUSE_DRAIN = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;

  // counters of one bin
  typedef struct packed {
    cnt_t alloc;
    cnt_t true_cnt;
  } bin_cnt_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                  add_en;
    logic [BIN_PORT_W-1:0] add_bin;
    logic [ADD_W-1:0]      add_true;
    logic [ADD_W-1:0]      add_alloc;
    logic                  shift_en;
  } cell_ctrl_t;

  // saturating add of a part size onto a counter
  function automatic cnt_t sat_add(cnt_t a, logic [ADD_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W + 1 - ADD_W){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/lbsp_cell.sv -----
// ----------------------------------------------------------------------------
// lbsp_cell
// One bin: holds its counters, takes adds addressed to it and passes its
// contents to its neighbour when the ring rotates.
// ----------------------------------------------------------------------------
module lbsp_cell #(
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  lbsp_pkg::cell_ctrl_t ctrl,
  input  lbsp_pkg::bin_cnt_t  shift_in,
  output lbsp_pkg::bin_cnt_t  cnt,
  output lbsp_pkg::cnt_t      hit_alloc
);

  logic sel;

  assign sel = (ctrl.add_bin == lbsp_pkg::BIN_PORT_W'(INDEX));

  // counters: rotation has priority, adds only when the ring is still
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.shift_en) begin
      cnt <= shift_in;
    end else if (ctrl.add_en && sel) begin
      cnt.alloc    <= lbsp_pkg::sat_add(cnt.alloc, ctrl.add_alloc);
      cnt.true_cnt <= lbsp_pkg::sat_add(cnt.true_cnt, ctrl.add_true);
    end
  end

  // addressed read, merged by OR in the chain
  assign hit_alloc = sel ? cnt.alloc : '0;

endmodule

// ----- hw/rtl/lbsp_chain.sv -----
// ----------------------------------------------------------------------------
// lbsp_chain
// Ring of bin cells. Cell 0 is the head; on a rotation every cell takes its
// upper neighbour and the top cell takes the head, or zero when clearing.
// ----------------------------------------------------------------------------
module lbsp_chain #(
  parameter int NUM_BINS = lbsp_pkg::NUM_BINS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lbsp_pkg::cell_ctrl_t ctrl,
  input  logic                 clear_head,
  output lbsp_pkg::bin_cnt_t   head,
  output lbsp_pkg::cnt_t       sel_alloc,
  output logic                 rest_nonempty
);

  lbsp_pkg::bin_cnt_t cnt      [NUM_BINS];
  lbsp_pkg::bin_cnt_t shift_in [NUM_BINS];
  lbsp_pkg::cnt_t     hit      [NUM_BINS];

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
    if (i == NUM_BINS - 1) begin : g_top
      assign shift_in[i] = clear_head ? '0 : cnt[0];
    end else begin : g_mid
      assign shift_in[i] = cnt[i+1];
    end

    lbsp_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .shift_in (shift_in[i]),
      .cnt      (cnt[i]),
      .hit_alloc(hit[i])
    );
  end

  assign head = cnt[0];

  // addressed bin and any nonempty bin behind the head
  always_comb begin
    sel_alloc     = '0;
    rest_nonempty = 1'b0;
    for (int i = 0; i < NUM_BINS; i++) begin
      sel_alloc = sel_alloc | hit[i];
    end
    for (int i = 1; i < NUM_BINS; i++) begin
      rest_nonempty = rest_nonempty | (cnt[i].alloc != '0);
    end
  end

endmodule

// ----- hw/rtl/largest_bin_spill_policy_top.sv -----
// ----------------------------------------------------------------------------
// largest_bin_spill_policy_top
// Bin counters with a largest-bin flush policy and a final drain.
// ----------------------------------------------------------------------------
// An add transaction goes through accept, counter update, largest-bin
// compare and limit check; when no limit is reached it ends there. When a
// limit is reached, the add goes on with one full rotation of the bin ring.
// A finish is the accept step and one rotation. During a rotation one bin
// passes the head each cycle unless the rotation stalls, the flushed bin is
// read out and cleared, and after an add the new largest bin is found. The
// rotation stalls while a result waits at the output and the next nonempty
// bin to be released reaches the head. No input is taken during a rotation;
// counters come out of reset cleared, so no clearing pass is needed.
// Configuration is always ready.
`include "largest_bin_spill_policy_top_defines.svh"

module largest_bin_spill_policy_top #(
  parameter int NUM_BINS = lbsp_pkg::NUM_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [lbsp_pkg::BIN_PORT_W-1:0]   bin,
  input  logic [lbsp_pkg::ADD_W-1:0]        true_bytes,
  input  logic [lbsp_pkg::ADD_W-1:0]        alloc_bytes,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lbsp_pkg::BIN_PORT_W-1:0]   flush_bin,
  output logic [lbsp_pkg::CNT_W-1:0]        flush_alloc_bytes,
  output logic [lbsp_pkg::CNT_W-1:0]        flush_true_bytes,
  output logic                              cause,
  output logic                              last,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbsp_pkg::CNT_W-1:0]        cfg_data
);

  localparam int IDX_W = $clog2(NUM_BINS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_COMPARE,
    ST_CHECK,
    ST_PASS
  } state_t;

  state_t state;

  logic [lbsp_pkg::BIN_PORT_W-1:0] bin_q;
  logic [lbsp_pkg::ADD_W-1:0]      true_q;
  logic [lbsp_pkg::ADD_W-1:0]      alloc_q;
  logic                            drain_q;
  logic [IDX_W-1:0]                idx;
  lbsp_pkg::cnt_t                  scan_max;
  logic [IDX_W-1:0]                scan_bin;
  lbsp_pkg::cnt_t                  total_buffered;
  lbsp_pkg::cnt_t                  largest_size;
  logic [IDX_W-1:0]                largest_bin;
  lbsp_pkg::cnt_t                  total_limit;
  lbsp_pkg::cnt_t                  package_limit;

  lbsp_pkg::cell_ctrl_t ctrl;
  lbsp_pkg::bin_cnt_t   head;
  lbsp_pkg::cnt_t       sel_alloc;
  logic                 rest_nonempty;

  logic           clear_now;
  logic           emit;
  logic           out_free;
  logic           step;
  logic           pass_end;
  logic           drain_end;
  logic           add_take;
  lbsp_pkg::cnt_t scan_val;
  logic           scan_take;
  logic           bin_ok;
  lbsp_pkg::cnt_t total_released;

  lbsp_chain #(
    .NUM_BINS(NUM_BINS)
  ) u_chain (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .clear_head   (clear_now),
    .head         (head),
    .sel_alloc    (sel_alloc),
    .rest_nonempty(rest_nonempty)
  );

  // rotation control: head bin is idx
  assign clear_now = drain_q || (idx == largest_bin);
  assign emit      = (state == ST_PASS) && clear_now && (head.alloc != '0);
  assign out_free  = !out_valid || out_ready;
  assign step      = (state == ST_PASS) && (!emit || out_free);
  assign pass_end  = (idx == IDX_W'(NUM_BINS - 1));
  assign drain_end = step && pass_end && drain_q;
  assign scan_val  = clear_now ? '0 : head.alloc;
  assign scan_take = (idx == '0) || (scan_val > scan_max);

  assign bin_ok   = ({1'b0, bin} < (lbsp_pkg::BIN_PORT_W + 1)'(NUM_BINS));
  assign add_take = in_valid && in_ready && (cmd == lbsp_pkg::CMD_ADD) && bin_ok;
  assign total_released = (total_buffered > head.alloc) ?
                          (total_buffered - head.alloc) : '0;

  // cell broadcast
  always_comb begin
    ctrl.add_en    = (state == ST_UPDATE);
    ctrl.add_bin   = bin_q;
    ctrl.add_true  = true_q;
    ctrl.add_alloc = alloc_q;
    ctrl.shift_en  = step;
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer, policy state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      drain_q        <= 1'b0;
      idx            <= '0;
      total_buffered <= '0;
      largest_size   <= '0;
      largest_bin    <= '0;
      total_limit    <= lbsp_pkg::TOTAL_LIMIT_RST;
      package_limit  <= lbsp_pkg::PACKAGE_LIMIT_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          lbsp_pkg::REG_TOTAL_LIMIT:   total_limit   <= cfg_data;
          lbsp_pkg::REG_PACKAGE_LIMIT: package_limit <= cfg_data;
          default: ;
        endcase
      end

      // result register: loaded on a release, held until taken
      out_valid <= (step && emit) || (out_valid && !out_ready);
      if (step && emit) begin
        flush_bin         <= lbsp_pkg::BIN_PORT_W'(idx);
        flush_alloc_bytes <= head.alloc;
        flush_true_bytes  <= head.true_cnt;
        cause             <= drain_q ? lbsp_pkg::CAUSE_DRAIN : lbsp_pkg::CAUSE_LIMIT;
        last              <= drain_q ? !rest_nonempty : 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            bin_q   <= bin;
            true_q  <= true_bytes;
            alloc_q <= alloc_bytes;
            drain_q <= (cmd == lbsp_pkg::CMD_FINISH);
            idx     <= '0;
            if (cmd == lbsp_pkg::CMD_FINISH) begin
              state <= ST_PASS;
            end else if (add_take) begin
              state <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          total_buffered <= lbsp_pkg::sat_add(total_buffered, alloc_q);
          state          <= ST_COMPARE;
        end
        ST_COMPARE: begin
          if (sel_alloc > largest_size) begin
            largest_size <= sel_alloc;
            largest_bin  <= bin_q[IDX_W-1:0];
          end
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if ((total_buffered >= total_limit) || (largest_size >= package_limit)) begin
            state <= ST_PASS;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PASS: begin
          if (step) begin
            // a finish ends with the total cleared
            if (drain_end) begin
              total_buffered <= '0;
            end else if (emit) begin
              total_buffered <= total_released;
            end
            if (scan_take) begin
              scan_max <= scan_val;
              scan_bin <= idx;
            end
            idx <= pass_end ? '0 : idx + 1'b1;
            if (pass_end) begin
              state <= ST_IDLE;
              if (drain_q) begin
                largest_size <= '0;
                largest_bin  <= '0;
              end else begin
                largest_size <= scan_take ? scan_val : scan_max;
                largest_bin  <= scan_take ? idx : scan_bin;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `LBSP_ASSERT_NEXT(a_drain_total, drain_end, total_buffered == '0, "finish left total set")
  `LBSP_ASSERT_NEXT(a_drain_largest, drain_end, largest_size == '0, "finish left largest set")
  `LBSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "waiting result dropped")
  `LBSP_ASSERT_NEXT(a_add_update, add_take, state == ST_UPDATE, "accepted add missed update")

endmodule
